### rtl/xoshiro256ss_random_generator_core_defines.svh
// Assertion macros shared by the xoshiro256** generator RTL.
// No dependencies; included by xsrg_ctrl, the only module that carries assertions.
`ifndef XOSHIRO256SS_RANDOM_GENERATOR_CORE_DEFINES_SVH
`define XOSHIRO256SS_RANDOM_GENERATOR_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define XSRG_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define XSRG_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/xsrg_pkg.sv
// Shared types and constants for the xoshiro256** generator.
// No dependencies; used by the controller, the datapath and the top level.
package xsrg_pkg;

  localparam int unsigned WordW = 64;

  // Item kinds carried on the input tuser
  localparam logic [1:0] OP_RESEED = 2'd0;
  localparam logic [1:0] OP_RAW    = 2'd1;
  localparam logic [1:0] OP_RANGE  = 2'd2;

  // Result source select
  localparam logic [1:0] OUT_ZERO  = 2'd0;
  localparam logic [1:0] OUT_RAW   = 2'd1;
  localparam logic [1:0] OUT_RANGE = 2'd2;

  // splitmix64 constants
  localparam logic [WordW-1:0] GOLD_INC  = 64'h9e37_79b9_7f4a_7c15;
  localparam logic [WordW-1:0] MIX_MUL_A = 64'hbf58_476d_1ce4_e5b9;
  localparam logic [WordW-1:0] MIX_MUL_B = 64'h94d0_49bb_1331_11eb;

  // Controller to datapath commands
  typedef struct packed {
    logic       seed_start;  // load splitmix accumulator from seed plus increment
    logic       seed_zero;   // use zero instead of the seed register
    logic       draw;        // scramble word 1, advance state, set up range multiply
    logic       mix1_load;   // first splitmix multiply operands
    logic       mix2_load;   // second splitmix multiply operands
    logic       mul_issue;   // form one 32x32 partial product
    logic [1:0] mul_part;    // bit 1: high half of A, bit 0: high half of B
    logic       acc_add;     // accumulate the registered partial product
    logic [1:0] acc_part;    // partial index of the registered product
    logic       store;       // finish splitmix round into a state word
    logic [1:0] word_idx;
    logic       out_load;
    logic [1:0] out_sel;
  } cmd_t;

endpackage

### rtl/xoshiro256ss_random_generator_core.sv
// xoshiro256** generator with splitmix64 reseeding. Raw item: the draw is
// registered, then the result is loaded once the output register is free.
// Range item: four passes through the shared 32x32 multiplier. Reseed: 4
// splitmix rounds on that multiplier. One item in work at a time; the next is
// taken the cycle after the result is loaded. After reset the block runs a
// seed-zero expansion with tready low; configuration writes are taken.
module xoshiro256ss_random_generator_core (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [63:0]  cfg_wdata_i,     // seed
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [127:0] s_axis_tdata,    // [63:0] low_bound, [127:64] high_bound
  input  logic [1:0]   s_axis_tuser,    // [1:0] op
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [63:0]  m_axis_tdata     // [63:0] value
);

  xsrg_pkg::cmd_t cmd;

  xsrg_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .s_op_i    (s_axis_tuser),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .cmd_o     (cmd)
  );

  xsrg_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .low_bound_i  (s_axis_tdata[63:0]),
    .high_bound_i (s_axis_tdata[127:64]),
    .cmd_i        (cmd),
    .value_o      (m_axis_tdata)
  );

endmodule

### rtl/xsrg_datapath.sv
// Datapath: state words, seed register, splitmix accumulator, shared 32x32
// multiplier with 128-bit accumulator and the output register. Uses xsrg_pkg.
module xsrg_datapath (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [xsrg_pkg::WordW-1:0]      cfg_wdata_i,
  input  logic [xsrg_pkg::WordW-1:0]      low_bound_i,
  input  logic [xsrg_pkg::WordW-1:0]      high_bound_i,
  input  xsrg_pkg::cmd_t                  cmd_i,
  output logic [xsrg_pkg::WordW-1:0]      value_o
);

  localparam int unsigned W = xsrg_pkg::WordW;

  logic [W-1:0]   seed_q;
  logic [W-1:0]   words_q [4];
  logic [W-1:0]   sm_q;
  logic [W-1:0]   mul_a_q, mul_b_q;
  logic [W-1:0]   prod_q;
  logic [2*W-1:0] acc_q;
  logic [W-1:0]   lo_q;
  logic [W-1:0]   raw_q;
  logic [W-1:0]   out_q;

  logic [W-1:0]   scr_x, scr_r, scr_out;
  logic [W-1:0]   t17, n0, n1, n2, n3;
  logic [W-1:0]   seed_base, sm_mix, acc_mix, acc_fin;
  logic [31:0]    a_half, b_half;
  logic [2*W-1:0] prod_sh;
  logic [W-1:0]   range_val;

  // Scrambler: rotl(w1 * 5, 7) * 9 by shift and add
  always_comb begin
    scr_x   = words_q[1] + (words_q[1] << 2);
    scr_r   = {scr_x[W-8:0], scr_x[W-1:W-7]};
    scr_out = scr_r + (scr_r << 3);
  end

  // xoshiro256 transition
  always_comb begin
    t17 = words_q[1] << 17;
    n2  = words_q[2] ^ words_q[0];
    n3  = words_q[3] ^ words_q[1];
    n1  = words_q[1] ^ n2;
    n0  = words_q[0] ^ n3;
  end

  always_comb begin
    seed_base = cmd_i.seed_zero ? '0 : seed_q;
    sm_mix    = sm_q ^ (sm_q >> 30);
    acc_mix   = acc_q[W-1:0] ^ (acc_q[W-1:0] >> 27);
    acc_fin   = acc_q[W-1:0] ^ (acc_q[W-1:0] >> 31);
    a_half    = cmd_i.mul_part[1] ? mul_a_q[W-1:32] : mul_a_q[31:0];
    b_half    = cmd_i.mul_part[0] ? mul_b_q[W-1:32] : mul_b_q[31:0];
    case (cmd_i.acc_part)
      2'd0:    prod_sh = {{W{1'b0}}, prod_q};
      2'd3:    prod_sh = {prod_q, {W{1'b0}}};
      default: prod_sh = {{32{1'b0}}, prod_q, {32{1'b0}}};
    endcase
    range_val = lo_q + acc_q[116:53];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= '0;
    end else if (cfg_we_i) begin
      seed_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.seed_start) begin
      sm_q <= seed_base + xsrg_pkg::GOLD_INC;
    end else if (cmd_i.store) begin
      sm_q <= sm_q + xsrg_pkg::GOLD_INC;
    end

    if (cmd_i.draw) begin
      words_q[0] <= n0;
      words_q[1] <= n1;
      words_q[2] <= n2 ^ t17;
      words_q[3] <= {n3[W-46:0], n3[W-1:W-45]};
    end else if (cmd_i.store) begin
      words_q[cmd_i.word_idx] <= acc_fin;
    end

    if (cmd_i.draw) begin
      raw_q   <= scr_out;
      mul_a_q <= {11'b0, scr_out[W-1:11]};
      mul_b_q <= high_bound_i - low_bound_i;
      lo_q    <= low_bound_i;
    end else if (cmd_i.mix1_load) begin
      mul_a_q <= sm_mix;
      mul_b_q <= xsrg_pkg::MIX_MUL_A;
    end else if (cmd_i.mix2_load) begin
      mul_a_q <= acc_mix;
      mul_b_q <= xsrg_pkg::MIX_MUL_B;
    end

    if (cmd_i.mul_issue) begin
      prod_q <= a_half * b_half;
    end

    // Clear on every operand load; mix2 reads the old sum in the same cycle
    if (cmd_i.draw || cmd_i.mix1_load || cmd_i.mix2_load) begin
      acc_q <= '0;
    end else if (cmd_i.acc_add) begin
      acc_q <= acc_q + prod_sh;
    end

    if (cmd_i.out_load) begin
      case (cmd_i.out_sel)
        xsrg_pkg::OUT_RAW:   out_q <= raw_q;
        xsrg_pkg::OUT_RANGE: out_q <= range_val;
        default:             out_q <= '0;
      endcase
    end
  end

  assign value_o = out_q;

endmodule

### rtl/xsrg_ctrl.sv
// Controller: sequences reseed, draw and range multiply, owns the handshake
// state and the output valid flag. Uses xsrg_pkg and the defines header.
`include "xoshiro256ss_random_generator_core_defines.svh"

module xsrg_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           s_valid_i,
  output logic           s_ready_o,
  input  logic [1:0]     s_op_i,
  output logic           m_valid_o,
  input  logic           m_ready_i,
  output xsrg_pkg::cmd_t cmd_o
);

  localparam logic [2:0] ST_INIT  = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_MIX1  = 3'd2;
  localparam logic [2:0] ST_MUL   = 3'd3;
  localparam logic [2:0] ST_MIX2  = 3'd4;
  localparam logic [2:0] ST_STORE = 3'd5;
  localparam logic [2:0] ST_DONE  = 3'd6;

  localparam logic [1:0] PH_MIX1  = 2'd0;
  localparam logic [1:0] PH_MIX2  = 2'd1;
  localparam logic [1:0] PH_RANGE = 2'd2;

  logic [2:0] st_q, st_d;
  logic [1:0] phase_q, phase_d;
  logic [2:0] cnt_q, cnt_d;
  logic [1:0] widx_q, widx_d;
  logic       init_q, init_d;
  logic [1:0] sel_q, sel_d;
  logic       out_valid_q, out_valid_d;
  logic       accept, out_free, mul_last;

  always_comb begin
    accept      = s_valid_i && (st_q == ST_IDLE);
    out_free    = !out_valid_q || m_ready_i;
    mul_last    = (phase_q == PH_RANGE) ? (cnt_q == 3'd4) : (cnt_q == 3'd3);
    st_d        = st_q;
    phase_d     = phase_q;
    cnt_d       = cnt_q;
    widx_d      = widx_q;
    init_d      = init_q;
    sel_d       = sel_q;
    out_valid_d = out_valid_q && !m_ready_i;
    cmd_o       = '0;

    case (st_q)
      ST_INIT: begin
        cmd_o.seed_start = 1'b1;
        cmd_o.seed_zero  = 1'b1;
        init_d           = 1'b1;
        widx_d           = '0;
        st_d             = ST_MIX1;
      end
      ST_IDLE: begin
        if (accept) begin
          case (s_op_i)
            xsrg_pkg::OP_RESEED: begin
              cmd_o.seed_start = 1'b1;
              init_d           = 1'b0;
              widx_d           = '0;
              sel_d            = xsrg_pkg::OUT_ZERO;
              st_d             = ST_MIX1;
            end
            xsrg_pkg::OP_RAW: begin
              cmd_o.draw = 1'b1;
              sel_d      = xsrg_pkg::OUT_RAW;
              st_d       = ST_DONE;
            end
            xsrg_pkg::OP_RANGE: begin
              cmd_o.draw = 1'b1;
              phase_d    = PH_RANGE;
              cnt_d      = '0;
              sel_d      = xsrg_pkg::OUT_RANGE;
              st_d       = ST_MUL;
            end
            default: begin
              sel_d = xsrg_pkg::OUT_ZERO;
              st_d  = ST_DONE;
            end
          endcase
        end
      end
      ST_MIX1: begin
        cmd_o.mix1_load = 1'b1;
        phase_d         = PH_MIX1;
        cnt_d           = '0;
        st_d            = ST_MUL;
      end
      ST_MUL: begin
        // Issue partial cnt, accumulate partial cnt-1; truncated products skip hi*hi
        cmd_o.mul_issue = !mul_last;
        cmd_o.mul_part  = cnt_q[1:0];
        cmd_o.acc_add   = (cnt_q != 3'd0);
        cmd_o.acc_part  = 2'(cnt_q - 3'd1);
        if (mul_last) begin
          cnt_d = '0;
          case (phase_q)
            PH_MIX1: st_d = ST_MIX2;
            PH_MIX2: st_d = ST_STORE;
            default: st_d = ST_DONE;
          endcase
        end else begin
          cnt_d = cnt_q + 3'd1;
        end
      end
      ST_MIX2: begin
        cmd_o.mix2_load = 1'b1;
        phase_d         = PH_MIX2;
        cnt_d           = '0;
        st_d            = ST_MUL;
      end
      ST_STORE: begin
        cmd_o.store    = 1'b1;
        cmd_o.word_idx = widx_q;
        widx_d         = widx_q + 2'd1;
        if (widx_q == 2'd3) begin
          st_d = init_q ? ST_IDLE : ST_DONE;
        end else begin
          st_d = ST_MIX1;
        end
      end
      ST_DONE: begin
        // Hold until the output register is free or being emptied
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_sel  = sel_q;
          out_valid_d    = 1'b1;
          st_d           = ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_INIT;
      phase_q     <= PH_MIX1;
      cnt_q       <= '0;
      widx_q      <= '0;
      init_q      <= 1'b1;
      sel_q       <= xsrg_pkg::OUT_ZERO;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      phase_q     <= phase_d;
      cnt_q       <= cnt_d;
      widx_q      <= widx_d;
      init_q      <= init_d;
      sel_q       <= sel_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign s_ready_o = (st_q == ST_IDLE);
  assign m_valid_o = out_valid_q;

  `XSRG_ASSERT_NEXT(a_raw_to_done, clk_i, rst_ni, accept && (s_op_i == xsrg_pkg::OP_RAW), st_q == ST_DONE, "raw item did not go straight to result")
  `XSRG_ASSERT_IMP(a_load_free, clk_i, rst_ni, cmd_o.out_load, out_free, "result loaded over an untaken result")
  `XSRG_ASSERT_NEXT(a_one_item, clk_i, rst_ni, accept, !s_ready_o, "second item taken while one is in work")
  `XSRG_ASSERT_IMP(a_cnt_range, clk_i, rst_ni, 1'b1, cnt_q <= 3'd4, "partial product counter out of range")

endmodule
